### rtl/pfps_pkg.sv
// Shared types, constants and helpers for the plane-strain phase-field point core.
// No dependencies; every other file imports it.
package pfps_pkg;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 504;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STRAIN_W   = 32;
  localparam int unsigned DAMAGE_W   = 17;
  localparam int unsigned VAL_W      = 48;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_NORMAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COUPLING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SHEAR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL      = 2'd3;

  localparam logic [DAMAGE_W-1:0] DAMAGE_ONE = 17'd65536;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_MUL1,
    ST_EFF,
    ST_MUL2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic mul1;
    logic eff;
    logic mul2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mod_busy;
    logic out_free;
  } status_t;

  // Saturate a signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sh0000_7FFF_FFFF_FFFF;
    lo_lim = -64'sh0000_8000_0000_0000;
    if (v > hi_lim) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo_lim) begin
      return 48'sh8000_0000_0000;
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

### rtl/pfps_ctrl.sv
// Sequencer for the point core: clearing pass, index wrap, and the four compute steps.
// Depends on pfps_pkg.
module pfps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pfps_pkg::status_t status,
  output pfps_pkg::cmd_t    cmd
);
  import pfps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_MOD;
      ST_MOD:   if (!status.mod_busy) state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_EFF;
      ST_EFF:   state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_FIN;
      ST_FIN:   if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_MOD:  cmd.mod_step = status.mod_busy;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_EFF:  cmd.eff = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_FIN:  cmd.finish = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/pfps_datapath.sv
// Datapath of the point core: registers, shared multipliers, history memory, output stage.
// Depends on pfps_pkg.
module pfps_datapath #(
  parameter int unsigned NUM_POINTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pfps_pkg::cmd_t                      cmd,
  output pfps_pkg::status_t                   status,
  input  logic                                cfg_wr_en,
  input  logic [pfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfps_pkg::COEF_W-1:0]         cfg_wr_data,
  input  logic [pfps_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pfps_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser
);
  import pfps_pkg::*;

  localparam int unsigned AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned NW = $clog2(NUM_POINTS + 1) + 1;

  // configuration
  logic [COEF_W-1:0] coef_normal, coef_coupling, coef_shear;
  logic [RES_W-1:0]  residual;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_normal   <= '0;
      coef_coupling <= '0;
      coef_shear    <= '0;
      residual      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COEF_NORMAL:   coef_normal   <= cfg_wr_data;
        REG_COEF_COUPLING: coef_coupling <= cfg_wr_data;
        REG_COEF_SHEAR:    coef_shear    <= cfg_wr_data;
        REG_RESIDUAL:      residual      <= cfg_wr_data[RES_W-1:0];
        default:           residual      <= residual;
      endcase
    end
  end

  // input capture
  logic [IDX_W-1:0]           idx_r;
  logic signed [STRAIN_W-1:0] e_r [3];
  logic [DAMAGE_W-1:0]        om_r;
  logic                       upd_r;
  logic [DAMAGE_W-1:0]        dmg_in;

  assign dmg_in = s_tdata[122:106];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= s_tdata[9:0];
      e_r[0] <= s_tdata[41:10];
      e_r[1] <= s_tdata[73:42];
      e_r[2] <= s_tdata[105:74];
      om_r   <= (dmg_in > DAMAGE_ONE) ? '0 : DAMAGE_ONE - dmg_in;
      upd_r  <= s_tuser;
    end else if (cmd.mod_step) begin
      idx_r <= IDX_W'(NW'(idx_r) - NW'(NUM_POINTS));
    end
  end

  assign status.mod_busy = NW'(idx_r) >= NW'(NUM_POINTS);

  // clearing pass and history memory
  logic [AW:0]        clr_cnt;
  logic               clearing;
  logic [AW-1:0]      addr;
  logic [VAL_W-1:0]   hist_mem [NUM_POINTS];
  logic [VAL_W-1:0]   hist_q;
  logic [VAL_W-1:0]   cur_energy;
  logic               mem_we;

  assign clearing          = clr_cnt < (AW+1)'(NUM_POINTS);
  assign status.clear_done = clr_cnt == (AW+1)'(NUM_POINTS - 1);
  assign addr              = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign mem_we = cmd.finish && upd_r;

  always_ff @(posedge clk) begin
    if (clearing) begin
      hist_mem[clr_cnt[AW-1:0]] <= '0;
    end else if (mem_we) begin
      hist_mem[addr] <= cur_energy;
    end
    if (cmd.mul1) begin
      hist_q <= hist_mem[addr];
    end
  end

  // step 1: coefficient products and om squared
  logic signed [64:0] p_n0, p_c1, p_n1, p_c0, p_s2;
  logic [33:0]        omsq;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p_n0 <= $signed({1'b0, coef_normal})   * e_r[0];
      p_c1 <= $signed({1'b0, coef_coupling}) * e_r[1];
      p_n1 <= $signed({1'b0, coef_normal})   * e_r[1];
      p_c0 <= $signed({1'b0, coef_coupling}) * e_r[0];
      p_s2 <= $signed({1'b0, coef_shear})    * e_r[2];
      omsq <= om_r * om_r;
    end
  end

  // step 2: effective stress and degradation
  logic signed [VAL_W-1:0] eff [3];
  logic [DAMAGE_W-1:0]     g_r;

  always_ff @(posedge clk) begin
    if (cmd.eff) begin
      eff[0] <= sat48(64'(p_n0 >>> 14) + 64'(p_c1 >>> 14));
      eff[1] <= sat48(64'(p_n1 >>> 14) + 64'(p_c0 >>> 14));
      eff[2] <= sat48(64'(p_s2 >>> 14));
      g_r    <= DAMAGE_W'(omsq >> 16) + DAMAGE_W'(residual);
    end
  end

  // step 3: split products for energy, stress and damage derivative
  logic signed [47:0] en_hi [3];
  logic signed [64:0] en_lo [3];
  logic signed [33:0] g_hi  [3];
  logic signed [50:0] g_lo  [3];
  logic signed [33:0] o_hi  [3];
  logic signed [50:0] o_lo  [3];

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      for (int k = 0; k < 3; k++) begin
        en_hi[k] <= $signed(eff[k][47:32]) * e_r[k];
        en_lo[k] <= $signed({1'b0, eff[k][31:0]}) * e_r[k];
        g_hi[k]  <= $signed({1'b0, g_r}) * $signed(eff[k][47:32]);
        g_lo[k]  <= $signed({1'b0, g_r}) * $signed({1'b0, eff[k][31:0]});
        o_hi[k]  <= $signed({1'b0, om_r}) * $signed(eff[k][47:32]);
        o_lo[k]  <= $signed({1'b0, om_r}) * $signed({1'b0, eff[k][31:0]});
      end
    end
  end

  // step 4: combine, compare with history, saturate
  logic signed [63:0]      elastic;
  logic signed [63:0]      elastic_sat;
  logic                    loading;
  logic signed [VAL_W-1:0] stress [3];
  logic signed [VAL_W-1:0] dph    [3];
  localparam logic signed [63:0] MASK48 = 64'sh0000_FFFF_FFFF_FFFF;

  always_comb begin
    elastic = '0;
    for (int k = 0; k < 3; k++) begin
      elastic = elastic + (64'(en_hi[k]) <<< 1) + 64'(en_lo[k] >>> 31);
      stress[k] = sat48((64'(g_hi[k]) <<< 16) + 64'(g_lo[k] >>> 16));
      dph[k]    = sat48(-(64'(o_hi[k]) <<< 17) + ((-64'(o_lo[k])) >>> 15));
    end
    elastic_sat = (elastic > MASK48) ? MASK48 : elastic;
    loading     = elastic_sat >= $signed({16'b0, hist_q});
    cur_energy  = loading ? elastic_sat[VAL_W-1:0] : hist_q;
  end

  // output register
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata[47:0]    <= stress[0];
      m_tdata[95:48]   <= stress[1];
      m_tdata[143:96]  <= stress[2];
      m_tdata[191:144] <= cur_energy;
      m_tdata[239:192] <= dph[0];
      m_tdata[287:240] <= dph[1];
      m_tdata[335:288] <= dph[2];
      m_tdata[383:336] <= loading ? eff[0] : '0;
      m_tdata[431:384] <= loading ? eff[1] : '0;
      m_tdata[479:432] <= loading ? eff[2] : '0;
      m_tdata[496:480] <= g_r;
      m_tdata[503:497] <= '0;
      m_tuser          <= loading;
    end
  end

endmodule

### rtl/phase_field_plane_strain_point_core.sv
// Plane-strain phase-field point core: one result item per input item.
// After acceptance, an out-of-range point index is wrapped by subtracting NUM_POINTS,
// then the MUL1, EFF, MUL2 and FIN steps follow; FIN loads the output register.
// A new item is taken only once the last one has left FIN: the sequencer works one
// item through the shared multiplier steps and the history read-modify-write.
// Reset: synchronous; clears registers, then a clearing pass zeroes the history memory,
// during which s_tready stays low.
module phase_field_plane_strain_point_core #(
  parameter int unsigned NUM_POINTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [pfps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfps_pkg::COEF_W-1:0]        cfg_wr_data,
  // input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // point_index[9:0], strain_xx[41:10], strain_yy[73:42], strain_xy[105:74],
  // damage[122:106], zero pad
  input  logic [pfps_pkg::IN_DATA_W-1:0]     s_tdata,
  // update_history
  input  logic                               s_tuser,
  // result items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // stress_xx, stress_yy, stress_xy, energy_density, dstress_dphase_xx/yy/xy,
  // denergy_dstrain_xx/yy/xy (48 bits each from bit 0), degradation[496:480], pad
  output logic [pfps_pkg::OUT_DATA_W-1:0]    m_tdata,
  // loading
  output logic                               m_tuser
);
  import pfps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: holds s_tready low except when idle and the history is clear.
  pfps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: stiffness products, energy, degradation, history store and output stage.
  pfps_datapath #(
    .NUM_POINTS (NUM_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

### dv/phase_field_plane_strain_point_core_tb.sv
// Self-checking testbench for the plane-strain phase-field point core.
// Drives point items over the stream port, predicts each result item and compares fields.
// Depends on rtl/pfps_pkg.sv and the core RTL.
`timescale 1ns / 100ps

module phase_field_plane_strain_point_core_tb;
  import pfps_pkg::*;

  localparam int NPTS = 1024;

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] exx;
    logic [31:0] eyy;
    logic [31:0] exy;
    logic [16:0] dmg;
    logic        upd;
  } point_t;

  typedef struct {
    logic [47:0] sxx, syy, sxy, energy, dxx, dyy, dxy, exx, eyy, exy;
    logic [16:0] degr;
    logic        load;
    logic        check_energy;  // directed rows with typed-in values
  } result_t;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 0, s_tready, s_tuser = 0, m_tvalid, m_tready = 0, m_tuser;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OUT_DATA_W-1:0] m_tdata;

  phase_field_plane_strain_point_core #(.NUM_POINTS(NPTS)) u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));

  // Predictor's own copy of the registers and the history store.
  logic [31:0] c11, c12, c33;
  logic [15:0] resid;
  logic [47:0] hist_mem [NPTS];
  result_t expected_results[$];
  int mismatches = 0;
  int send_idle = 0, recv_stall = 0;  // percent

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [63:0] sat_s48(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v[63:0];
  endfunction

  // Arithmetic shift right on a wide signed value floors toward minus infinity.
  function automatic result_t predict_point(input point_t p);
    result_t r;
    logic signed [127:0] e [3];
    logic signed [127:0] eff [3];
    logic signed [127:0] t, elastic, om, g;
    logic [47:0] h;
    logic [16:0] d;
    int unsigned ix;
    e[0] = $signed(p.exx); e[1] = $signed(p.eyy); e[2] = $signed(p.exy);
    eff[0] = sat_s48(((e[0] * $signed({1'b0, c11})) >>> 14)
                   + ((e[1] * $signed({1'b0, c12})) >>> 14));
    eff[1] = sat_s48(((e[1] * $signed({1'b0, c11})) >>> 14)
                   + ((e[0] * $signed({1'b0, c12})) >>> 14));
    eff[2] = sat_s48((e[2] * $signed({1'b0, c33})) >>> 14);
    elastic = 0;
    for (int k = 0; k < 3; k++) elastic += (eff[k] * e[k]) >>> 31;
    if (elastic > 128'shFFFF_FFFF_FFFF) elastic = 128'shFFFF_FFFF_FFFF;
    ix = p.idx % NPTS;
    h = hist_mem[ix];
    r.load = elastic >= $signed({80'd0, h});
    r.energy = r.load ? elastic[47:0] : h;
    d = (p.dmg > DAMAGE_ONE) ? DAMAGE_ONE : p.dmg;
    om = 65536 - d;
    g = ((om * om) >>> 16) + resid;
    r.degr = g[16:0];
    t = sat_s48((g * eff[0]) >>> 16); r.sxx = t[47:0];
    t = sat_s48((g * eff[1]) >>> 16); r.syy = t[47:0];
    t = sat_s48((g * eff[2]) >>> 16); r.sxy = t[47:0];
    t = sat_s48((-(om * eff[0])) >>> 15); r.dxx = t[47:0];
    t = sat_s48((-(om * eff[1])) >>> 15); r.dyy = t[47:0];
    t = sat_s48((-(om * eff[2])) >>> 15); r.dxy = t[47:0];
    r.exx = r.load ? eff[0][47:0] : '0;
    r.eyy = r.load ? eff[1][47:0] : '0;
    r.exy = r.load ? eff[2][47:0] : '0;
    r.check_energy = 0;
    if (p.upd) hist_mem[ix] = r.energy;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= ri; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    case (ri)
      REG_COEF_NORMAL:   c11 = v;
      REG_COEF_COUPLING: c12 = v;
      REG_COEF_SHEAR:    c33 = v;
      default:           resid = v[15:0];
    endcase
  endtask

  task automatic load_coefs(input logic [31:0] a, b, c, input logic [15:0] rs);
    write_reg(REG_COEF_NORMAL, a);
    write_reg(REG_COEF_COUPLING, b);
    write_reg(REG_COEF_SHEAR, c);
    write_reg(REG_RESIDUAL, {16'd0, rs});
  endtask

  // Drop tvalid, hold until every expected item has arrived, then let the pipe drain.
  task automatic drain_results();
    s_tvalid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Present one item at the falling edge and hold until accepted.
  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, p.dmg, p.exy, p.eyy, p.exx, p.idx};
    s_tuser <= p.upd;
    expected_results.push_back(predict_point(p));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_strain();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.idx = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15));
    p.exx = rand_strain(); p.eyy = rand_strain(); p.exy = rand_strain();
    case ($urandom_range(4))
      0: p.dmg = '0;
      1: p.dmg = DAMAGE_ONE;
      2: p.dmg = 17'($urandom);  // above one as well
      default: p.dmg = 17'($urandom_range(65536));
    endcase
    p.upd = 1'($urandom);
    return p;
  endfunction

  // Receiver: stall at random, compare each accepted item with the oldest expectation.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_t x;
      logic [47:0] got [10];
      logic [47:0] want [10];
      for (int k = 0; k < 10; k++) got[k] = m_tdata[k*48 +: 48];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $time);
      end else begin
        x = expected_results.pop_front();
        want = '{x.sxx, x.syy, x.sxy, x.energy, x.dxx, x.dyy, x.dxy, x.exx, x.eyy, x.exy};
        for (int k = 0; k < 10; k++)
          if (got[k] !== want[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h got %h", k, want[k], got[k]);
          end
        if (m_tdata[496:480] !== x.degr || m_tuser !== x.load) begin
          mismatches++;
          if (mismatches <= 10)
            $display("degradation/loading: expected %h/%b got %h/%b",
                     x.degr, x.load, m_tdata[496:480], m_tuser);
        end
        // Typed-in values: zero strain straight after reset.
        if (x.check_energy && (m_tdata[479:0] !== '0 || m_tdata[496:480] !== 17'h10000 ||
                               m_tuser !== 1'b1)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("after reset: expected zeros/10000/1 got %h/%h/%b",
                     m_tdata[479:0], m_tdata[496:480], m_tuser);
        end
      end
    end
  end

  // Directed table: extremes of every field and each special case.
  point_t dir_tab [11] = '{
    '{10'd0, 32'h0, 32'h0, 32'h0, 17'd0, 1'b1},
    '{10'd1, 32'h4000_0000, 32'h0, 32'h0, 17'd0, 1'b1},
    '{10'd1, 32'h1000_0000, 32'h0, 32'h0, 17'd0, 1'b0},       // unloading
    '{10'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0, 1'b1},
    '{10'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd65536, 1'b1},
    '{10'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd32768, 1'b0},
    '{10'd5, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001, 17'h1FFFF, 1'b1}, // over one
    '{10'd6, 32'hC000_0000, 32'h4000_0000, 32'h2000_0000, 17'd65537, 1'b0},
    '{10'h3FF, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 17'd1, 1'b1},
    '{10'h3FF, 32'h0, 32'h0, 32'h0, 17'd65535, 1'b0},   // no update, history kept
    '{10'd2, 32'h0, 32'h0, 32'h0, 17'd0, 1'b1}
  };

  initial begin
    point_t p;
    for (int i = 0; i < NPTS; i++) hist_mem[i] = '0;
    c11 = 0; c12 = 0; c33 = 0; resid = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // After reset everything is zero: degradation one, energy zero, loading set.
    p = dir_tab[0];
    send_point(p);
    expected_results[$].check_energy = 1;
    drain_results();

    load_coefs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 16'd100);
    foreach (dir_tab[i]) send_point(dir_tab[i]);
    drain_results();
    load_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    foreach (dir_tab[i]) send_point(dir_tab[i]);
    drain_results();

    // Random phases with different coefficient settings and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      if (ph == 7) load_coefs(32'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
      else load_coefs($urandom, $urandom, $urandom, 16'($urandom));
      for (int i = 0; i < 170; i++) begin
        if (i == 85) drain_results();
        send_point(rand_point());
      end
      drain_results();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
